>>> hw/rtl/assert_macros.svh
// Assertion helpers for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/twm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twm_pkg;

   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int CNT_W      = 2;
   localparam int SUM_W      = 32;
   localparam int MILLI_W    = 11;
   localparam int WSUM_W     = 12;
   localparam int SIZE_W     = 12;
   localparam int WEIGHT_W   = 10;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int PROD_W     = SUM_W + SIZE_W;
   localparam int DIGIT_W    = 15;
   localparam int NUM_DIGITS = 3;
   localparam int DIVIDEND_W = DIGIT_W * NUM_DIGITS;
   localparam int QUOT_W     = 35;
   localparam int REM_W      = 10;
   localparam int STEP_W     = REM_W + DIGIT_W;
   localparam int RECIP_W    = 26;
   localparam int RECIP_SHIFT = STEP_W + REM_W;
   localparam int RECIP_PROD_W = STEP_W + RECIP_W;
   localparam int PX_W       = 31;

   // ceil(2^35 / 1000): exact quotient for every 25-bit step value
   localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;
   localparam logic [REM_W-1:0]   DIVISOR   = 10'd1000;
   localparam logic [REM_W-1:0]   HALF_DIVISOR = 10'd500;

   localparam logic [SIZE_W-1:0]   FONT_SIZE_RESET   = 12'd16;
   localparam logic [WEIGHT_W-1:0] FONT_WEIGHT_RESET = 10'd400;
   localparam logic [WEIGHT_W-1:0] BOLD_WEIGHT       = 10'd600;

   localparam logic [MILLI_W-1:0] MONO_MILLI  = 11'd600;
   localparam logic [MILLI_W-1:0] BOLD_BONUS  = 11'd40;
   localparam logic [MILLI_W-1:0] WIDE_MILLI  = 11'd1000;
   localparam logic [MILLI_W-1:0] OTHER_MILLI = 11'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FONT_SIZE   = 2'd0,
      CSR_FONT_WEIGHT = 2'd1,
      CSR_MONOSPACE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   font_size;
      logic [WEIGHT_W-1:0] font_weight;
      logic                monospace_mode;
   } cfg_type;

   // One long-division step by 1000 works on this: quotient so far,
   // running remainder and the dividend bits not yet brought down.
   typedef struct packed {
      logic [QUOT_W-1:0]     quot;
      logic [REM_W-1:0]      rem;
      logic [DIVIDEND_W-1:0] tail;
   } div_type;

   localparam logic [MILLI_W-1:0] ASCII_MILLI [128] = '{
      11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,
      11'd278, 11'd278, 11'd355, 11'd556, 11'd556, 11'd889, 11'd667, 11'd191,
      11'd333, 11'd333, 11'd389, 11'd584, 11'd278, 11'd333, 11'd278, 11'd278,
      11'd556, 11'd556, 11'd556, 11'd556, 11'd556, 11'd556, 11'd556, 11'd556,
      11'd556, 11'd556, 11'd278, 11'd278, 11'd584, 11'd584, 11'd584, 11'd556,
      11'd1015, 11'd667, 11'd667, 11'd722, 11'd722, 11'd667, 11'd611, 11'd778,
      11'd722, 11'd278, 11'd500, 11'd667, 11'd556, 11'd833, 11'd722, 11'd778,
      11'd667, 11'd778, 11'd722, 11'd667, 11'd611, 11'd722, 11'd667, 11'd944,
      11'd667, 11'd667, 11'd611, 11'd278, 11'd278, 11'd278, 11'd469, 11'd556,
      11'd333, 11'd556, 11'd556, 11'd500, 11'd556, 11'd556, 11'd278, 11'd556,
      11'd556, 11'd222, 11'd222, 11'd500, 11'd222, 11'd833, 11'd556, 11'd556,
      11'd556, 11'd556, 11'd333, 11'd500, 11'd278, 11'd556, 11'd500, 11'd722,
      11'd500, 11'd500, 11'd500, 11'd334, 11'd260, 11'd334, 11'd584, 11'd0
   };

   function automatic logic is_wide(input logic [CP_W-1:0] cp);
      return (cp >= 21'h01100 && cp <= 21'h0115f) ||
             (cp >= 21'h02e80 && cp <= 21'h0a4cf) ||
             (cp >= 21'h0ac00 && cp <= 21'h0d7a3) ||
             (cp >= 21'h0f900 && cp <= 21'h0faff) ||
             (cp >= 21'h0ff00 && cp <= 21'h0ff60) ||
             (cp >= 21'h20000 && cp <= 21'h3fffd);
   endfunction

   function automatic logic [MILLI_W-1:0] cp_width(input logic [CP_W-1:0] cp,
                                                   input logic bold,
                                                   input logic mono);
      logic [MILLI_W-1:0] bonus;
      logic [MILLI_W-1:0] w;
      bonus = bold ? BOLD_BONUS : '0;
      priority if (mono) begin
         w = MONO_MILLI;
      end else if (cp < 21'd128) begin
         w = ASCII_MILLI[cp[6:0]];
         if (w != '0) begin
            w = w + bonus;
         end
      end else if (is_wide(cp)) begin
         w = WIDE_MILLI;
      end else begin
         w = OTHER_MILLI + bonus;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/twm_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module twm_acc (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire twm_pkg::cfg_type             cfg,
   input  wire logic                         req_valid,
   input  wire logic [twm_pkg::BYTE_W-1:0]   req_text_byte,
   output logic                              req_stall,
   output logic                              tok_valid,
   output logic [twm_pkg::SUM_W-1:0]         tok_sum,
   input  wire logic                         tok_stall
);

   logic                          in_vld_ff, in_vld_in;
   logic [twm_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic [twm_pkg::CNT_W-1:0]     pend_cnt_ff, pend_cnt_in;
   logic [twm_pkg::CP_W-1:0]      pend_cp_ff, pend_cp_in;
   logic [twm_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic                          tok_vld_ff, tok_vld_in;
   logic [twm_pkg::SUM_W-1:0]     tok_sum_ff, tok_sum_in;

   logic                          has_pend, take_cont, is_term;
   logic                          lead2, lead3, lead4;
   logic [twm_pkg::CP_W-1:0]      ext_cp, cp_a;
   logic [twm_pkg::CNT_W-1:0]     cnt_dec;
   logic                          count_a, count_b, bold;
   logic [twm_pkg::MILLI_W-1:0]   w_a, w_b;
   logic [twm_pkg::WSUM_W-1:0]    wsum;
   logic [twm_pkg::SUM_W:0]       add;
   logic [twm_pkg::SUM_W-1:0]     sum_sat;
   logic                          tok_adv, fire, in_take;

   always_comb begin
      has_pend  = pend_cnt_ff != '0;
      take_cont = has_pend && (byte_ff[7:6] == 2'b10);
      is_term   = !take_cont && (byte_ff == '0);
      lead2     = byte_ff[7:5] == 3'b110;
      lead3     = byte_ff[7:4] == 4'b1110;
      lead4     = byte_ff[7:3] == 5'b11110;
      ext_cp    = {pend_cp_ff[twm_pkg::CP_W-7:0], byte_ff[5:0]};
      cnt_dec   = pend_cnt_ff - 2'd1;
      // a short sequence counts its partial code point before the new byte
      cp_a      = take_cont ? ext_cp : pend_cp_ff;
      count_a   = take_cont ? (cnt_dec == '0) : has_pend;
      count_b   = !take_cont && (byte_ff != '0) && !lead2 && !lead3 && !lead4;
      bold      = cfg.font_weight >= twm_pkg::BOLD_WEIGHT;
      w_a       = twm_pkg::cp_width(cp_a, bold, cfg.monospace_mode);
      w_b       = twm_pkg::cp_width({13'd0, byte_ff}, bold, cfg.monospace_mode);
      wsum      = (count_a ? {1'b0, w_a} : '0) + (count_b ? {1'b0, w_b} : '0);
      add       = {1'b0, sum_ff} + {21'd0, wsum};
      sum_sat   = add[twm_pkg::SUM_W] ? '1 : add[twm_pkg::SUM_W-1:0];

      tok_adv   = !tok_vld_ff || !tok_stall;
      fire      = in_vld_ff && (!is_term || tok_adv);
      req_stall = in_vld_ff && !fire;
      in_take   = req_valid && !req_stall;

      pend_cnt_in = pend_cnt_ff;
      pend_cp_in  = pend_cp_ff;
      sum_in      = sum_ff;
      if (fire) begin
         priority if (take_cont) begin
            pend_cnt_in = cnt_dec;
            pend_cp_in  = (cnt_dec == '0) ? '0 : ext_cp;
            sum_in      = sum_sat;
         end else if (is_term) begin
            pend_cnt_in = '0;
            pend_cp_in  = '0;
            sum_in      = '0;
         end else begin
            sum_in = sum_sat;
            priority if (lead2) begin
               pend_cnt_in = 2'd1;
               pend_cp_in  = {16'd0, byte_ff[4:0]};
            end else if (lead3) begin
               pend_cnt_in = 2'd2;
               pend_cp_in  = {17'd0, byte_ff[3:0]};
            end else if (lead4) begin
               pend_cnt_in = 2'd3;
               pend_cp_in  = {18'd0, byte_ff[2:0]};
            end else begin
               pend_cnt_in = '0;
               pend_cp_in  = '0;
            end
         end
      end

      tok_vld_in = (fire && is_term) ? 1'b1 : (tok_adv ? 1'b0 : tok_vld_ff);
      tok_sum_in = (fire && is_term) ? sum_sat : tok_sum_ff;
      in_vld_in  = in_take ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
      byte_in    = in_take ? req_text_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         tok_vld_ff  <= 1'b0;
         pend_cnt_ff <= '0;
         pend_cp_ff  <= '0;
         sum_ff      <= '0;
      end else begin
         in_vld_ff   <= in_vld_in;
         tok_vld_ff  <= tok_vld_in;
         pend_cnt_ff <= pend_cnt_in;
         pend_cp_ff  <= pend_cp_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      tok_sum_ff <= tok_sum_in;
   end

   assign tok_valid = tok_vld_ff;
   assign tok_sum   = tok_sum_ff;

endmodule

`default_nettype wire

>>> hw/rtl/twm_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module twm_div_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire twm_pkg::div_type  in_data,
   output logic                   in_stall,
   output logic                   out_valid,
   output twm_pkg::div_type       out_data,
   input  wire logic              out_stall
);

   logic                                 vld_ff, vld_in;
   twm_pkg::div_type                     data_ff, data_in, step;
   logic [twm_pkg::STEP_W-1:0]           v;
   logic [twm_pkg::RECIP_PROD_W-1:0]     prod;
   logic [twm_pkg::DIGIT_W-1:0]          q;
   logic [twm_pkg::STEP_W-1:0]           r;
   logic                                 adv;

   always_comb begin
      // bring down the next digit: remainder * 2^15 + digit
      v    = {in_data.rem, in_data.tail[twm_pkg::DIVIDEND_W-1 -: twm_pkg::DIGIT_W]};
      prod = twm_pkg::RECIP_PROD_W'(v) * twm_pkg::RECIP_PROD_W'(twm_pkg::DIV_RECIP);
      q    = prod[twm_pkg::RECIP_SHIFT +: twm_pkg::DIGIT_W];
      r    = v - twm_pkg::STEP_W'(q) * twm_pkg::STEP_W'(twm_pkg::DIVISOR);
      step.quot = {in_data.quot[twm_pkg::QUOT_W-twm_pkg::DIGIT_W-1:0], q};
      step.rem  = r[twm_pkg::REM_W-1:0];
      step.tail = in_data.tail << twm_pkg::DIGIT_W;

      adv      = !vld_ff || !out_stall;
      in_stall = !adv;
      vld_in   = adv ? in_valid : vld_ff;
      data_in  = (adv && in_valid) ? step : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_text_width_meter.sv
// Throughput: one text byte per cycle from a single decode/accumulate stage, unless a
// terminator waits behind a full token slot. A terminator's width reaches rsp_ through
// the input register, accumulate, 32x12 multiply, three divide-by-1000 digit stages and
// output register. Non-terminator bytes give no result; stalls back up stage by stage.
// Reset is synchronous: it clears decode state, the sum and all valid flags, and
// sets font_size 16, font_weight 400, monospace_mode 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_text_width_meter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [twm_pkg::BYTE_W-1:0]     req_text_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [twm_pkg::PX_W-1:0]            rsp_width_px,
   input  wire logic                           csr_we,
   input  wire logic [twm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [twm_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int NUM_STAGES = twm_pkg::NUM_DIGITS;

   logic [twm_pkg::SIZE_W-1:0]    font_size_ff, font_size_in;
   logic [twm_pkg::WEIGHT_W-1:0]  font_weight_ff, font_weight_in;
   logic                          mono_ff, mono_in;
   twm_pkg::cfg_type              cfg;

   logic                          tok_valid, tok_stall;
   logic [twm_pkg::SUM_W-1:0]     tok_sum;

   logic                          mul_vld_ff, mul_vld_in, mul_adv;
   logic [twm_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic                          d_vld   [NUM_STAGES+1];
   logic                          d_stall [NUM_STAGES+1];
   twm_pkg::div_type              d_data  [NUM_STAGES+1];

   logic                          rsp_vld_ff, rsp_vld_in, out_adv;
   logic [twm_pkg::PX_W-1:0]      px_ff, px_in;
   logic [twm_pkg::QUOT_W:0]      rounded;

   always_comb begin
      font_size_in   = font_size_ff;
      font_weight_in = font_weight_ff;
      mono_in        = mono_ff;
      if (csr_we) begin
         unique case (csr_index)
            twm_pkg::CSR_FONT_SIZE:   font_size_in   = csr_wdata;
            twm_pkg::CSR_FONT_WEIGHT: font_weight_in = csr_wdata[twm_pkg::WEIGHT_W-1:0];
            twm_pkg::CSR_MONOSPACE:   mono_in        = csr_wdata[0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
      cfg.font_size      = font_size_ff;
      cfg.font_weight    = font_weight_ff;
      cfg.monospace_mode = mono_ff;
   end

   twm_acc u_acc (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_text_byte (req_text_byte),
      .req_stall     (req_stall),
      .tok_valid     (tok_valid),
      .tok_sum       (tok_sum),
      .tok_stall     (tok_stall)
   );

   // scale the em sum by the font size
   always_comb begin
      mul_adv    = !mul_vld_ff || !d_stall[0];
      tok_stall  = !mul_adv;
      mul_vld_in = mul_adv ? tok_valid : mul_vld_ff;
      prod_in    = (mul_adv && tok_valid)
                   ? twm_pkg::PROD_W'(tok_sum) * twm_pkg::PROD_W'(font_size_ff)
                   : prod_ff;
      d_vld[0]       = mul_vld_ff;
      d_data[0].quot = '0;
      d_data[0].rem  = '0;
      d_data[0].tail = {1'b0, prod_ff};
   end

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_div
      twm_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_vld[k]),
         .in_data   (d_data[k]),
         .in_stall  (d_stall[k]),
         .out_valid (d_vld[k+1]),
         .out_data  (d_data[k+1]),
         .out_stall (d_stall[k+1])
      );
   end

   // round half up on the remainder, then clamp to the output range
   always_comb begin
      out_adv  = !rsp_vld_ff || !rsp_stall;
      d_stall[NUM_STAGES] = !out_adv;
      rounded  = {1'b0, d_data[NUM_STAGES].quot}
                 + (twm_pkg::QUOT_W+1)'(d_data[NUM_STAGES].rem >= twm_pkg::HALF_DIVISOR);
      rsp_vld_in = out_adv ? d_vld[NUM_STAGES] : rsp_vld_ff;
      if (out_adv && d_vld[NUM_STAGES]) begin
         px_in = (rounded[twm_pkg::QUOT_W:twm_pkg::PX_W] != '0)
                 ? '1 : rounded[twm_pkg::PX_W-1:0];
      end else begin
         px_in = px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_size_ff   <= twm_pkg::FONT_SIZE_RESET;
         font_weight_ff <= twm_pkg::FONT_WEIGHT_RESET;
         mono_ff        <= 1'b0;
         mul_vld_ff     <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         font_size_ff   <= font_size_in;
         font_weight_ff <= font_weight_in;
         mono_ff        <= mono_in;
         mul_vld_ff     <= mul_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      px_ff   <= px_in;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_width_px = px_ff;

   // only a terminator blocked behind a full token slot holds off the input
   `ASSERT_IMPLIES(a_stall_cause, req_stall, tok_valid && tok_stall)
   `ASSERT_IMPLIES(a_rem_range, d_vld[NUM_STAGES],
                   d_data[NUM_STAGES].rem < twm_pkg::DIVISOR)
   `ASSERT_NEXT(a_out_load, d_vld[NUM_STAGES] && !d_stall[NUM_STAGES], rsp_valid)

endmodule

`default_nettype wire
